// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SWPS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SWPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/swps_pkg.sv =====
// Types and constants of the servo waypoint sequencer.
`timescale 1ns / 1ps
package swps_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int JOINT_COUNT   = 6;
    localparam int ANGLE_BITS    = 16;
    localparam int GRIPPER_JOINT = 5;
    localparam int THR_W         = 16;
    localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ARM_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HAND_THR = 1'b1;

    typedef enum logic {
        CMD_PUSH   = 1'b0,
        CMD_STATUS = 1'b1
    } cmd_t;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef angle_t [JOINT_COUNT-1:0] waypoint_t;
    typedef logic [THR_W-1:0] thr_word_t;

    typedef struct packed {
        thr_word_t arm;
        thr_word_t hand;
    } thr_t;

    // Classified beat handed from front to back.
    typedef struct packed {
        logic      is_push;
        waypoint_t angles;
    } qitem_t;

    typedef struct packed {
        logic      target_valid;
        waypoint_t target;
        logic      moving;
        logic      advanced;
        logic      push_rejected;
    } res_t;

endpackage

// ===== rtl/swps_front.sv =====
// Front end: accepts input beats, classifies them, buffers them in a two-entry queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swps_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               item_cmd,
    input  swps_pkg::waypoint_t item_angles,
    output logic               q_valid,
    output swps_pkg::qitem_t   q_item,
    input  logic               q_pop
);
    import swps_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    qitem_t     slot_reg [2];
    logic       wr_en;
    qitem_t     wr_item;

    assign item_stall = (cnt_reg == Q_FULL);
    assign wr_en      = item_valid && !item_stall;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_item.is_push = (cmd_t'(item_cmd) == CMD_PUSH);
        wr_item.angles  = item_angles;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({wr_en, q_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `SWPS_ASSERT(a_front_cnt_bound, cnt_reg <= Q_FULL, "command queue overfilled")

endmodule

// ===== rtl/swps_back.sv =====
// Back end: waypoint FIFO, per-joint arrival check and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  swps_pkg::thr_t   thr,
    input  logic             q_valid,
    input  swps_pkg::qitem_t q_item,
    output logic             q_pop,
    output logic             res_valid,
    output swps_pkg::res_t   res,
    input  logic             res_stall
);
    import swps_pkg::*;

    localparam int ERR_W = ANGLE_BITS + 1;
    localparam int CMP_W = (ERR_W > THR_W) ? ERR_W : THR_W;

    typedef enum logic {
        ST_IDLE,
        ST_CMP
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    waypoint_t        meas_reg;
    waypoint_t        rd_data_reg;
    waypoint_t        waypoint_mem [QUEUE_DEPTH];

    logic             out_free;
    logic             full;
    logic             mem_we;
    logic             rd_en;
    logic             res_load;
    logic             all_ok;
    logic [JOINT_COUNT-1:0] joint_ok;

    assign out_free  = !res_valid_reg || !res_stall;
    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // One subtract / abs / compare lane per joint.
    always_comb
    begin
        logic signed [ERR_W-1:0] diff;
        logic [ERR_W-1:0]        err;
        logic [CMP_W-1:0]        thr_x;
        for (int j = 0; j < JOINT_COUNT; j++)
        begin
            diff = ERR_W'($signed(meas_reg[j])) - ERR_W'($signed(rd_data_reg[j]));
            err  = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
            thr_x = (j == GRIPPER_JOINT) ? CMP_W'(thr.hand) : CMP_W'(thr.arm);
            joint_ok[j] = (CMP_W'(err) <= thr_x);
        end
    end

    assign all_ok = &joint_ok;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        res_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    res_next = '0;
                    if (q_item.is_push)
                    begin
                        res_load = 1'b1;
                        res_next.moving = 1'b1;
                        res_next.push_rejected = full;
                        if (!full)
                        begin
                            mem_we    = 1'b1;
                            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                        '0 : tail_reg + PTR_W'(1);
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    res_load              = 1'b1;
                    res_next.target_valid = 1'b1;
                    res_next.target       = rd_data_reg;
                    res_next.advanced     = all_ok;
                    res_next.push_rejected = 1'b0;
                    res_next.moving       = all_ok ? (cnt_reg != CNT_W'(1)) : 1'b1;
                    if (all_ok)
                    begin
                        head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg + PTR_W'(1);
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and memory: no reset.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (mem_we)
        begin
            waypoint_mem[tail_reg] <= q_item.angles;
        end
        if (rd_en)
        begin
            rd_data_reg <= waypoint_mem[head_reg];
            meas_reg    <= q_item.angles;
        end
    end

    `SWPS_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(QUEUE_DEPTH), "waypoint count over depth")
    `SWPS_ASSERT_IMP(a_cmp_nonempty, state_reg == ST_CMP, cnt_reg != '0, "compare on empty FIFO")
    `SWPS_ASSERT_IMP(a_adv_target, res_valid_reg && res_reg.advanced, res_reg.target_valid, "advance without target")
    `SWPS_ASSERT_IMP(a_reject_push, res_valid_reg && res_reg.push_rejected, res_reg.moving && !res_reg.target_valid, "bad reject beat")

endmodule

// ===== rtl/servo_waypoint_sequencer_core.sv =====
// Top level of the servo waypoint sequencer: threshold registers, front and back.
`timescale 1ns / 1ps
// Path: a push, or a status beat on an empty FIFO, goes via a queue slot and the result
//   register; a status beat that finds a waypoint also goes via the memory read register.
// Throughput: one push per cycle while results are not stalled; a status beat with a
//   waypoint stops back-end pops during the compare state that the registered read needs.
// A two-beat command queue decouples input acceptance from the back end.
// Reset (rst_n low, async): FIFO empty, queues empty, thresholds 82 (arm) and 410 (hand).
module servo_waypoint_sequencer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               cmd,
    input  swps_pkg::angle_t                   angle_0,
    input  swps_pkg::angle_t                   angle_1,
    input  swps_pkg::angle_t                   angle_2,
    input  swps_pkg::angle_t                   angle_3,
    input  swps_pkg::angle_t                   angle_4,
    input  swps_pkg::angle_t                   angle_5,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               target_valid,
    output swps_pkg::angle_t                   target_0,
    output swps_pkg::angle_t                   target_1,
    output swps_pkg::angle_t                   target_2,
    output swps_pkg::angle_t                   target_3,
    output swps_pkg::angle_t                   target_4,
    output swps_pkg::angle_t                   target_5,
    output logic                               moving,
    output logic                               advanced,
    output logic                               push_rejected,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [swps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swps_pkg::THR_W-1:0]         cfg_data
);
    import swps_pkg::*;

    localparam thr_word_t ARM_THR_RST  = THR_W'(82);
    localparam thr_word_t HAND_THR_RST = THR_W'(410);

    thr_t      thr_reg, thr_next;
    waypoint_t in_angles;
    logic      q_valid;
    qitem_t    q_item;
    logic      q_pop;
    res_t      res;

    // Threshold registers: written only while the block is idle, by the user; unenforced.
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ARM_THR:  thr_next.arm  = cfg_data;
                REG_HAND_THR: thr_next.hand = cfg_data;
                default:      thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.arm  <= ARM_THR_RST;
            thr_reg.hand <= HAND_THR_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Joint 0 sits in the low element.
    assign in_angles[0] = angle_0;
    assign in_angles[1] = angle_1;
    assign in_angles[2] = angle_2;
    assign in_angles[3] = angle_3;
    assign in_angles[4] = angle_4;
    assign in_angles[5] = angle_5;

    swps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_cmd    (cmd),
        .item_angles (in_angles),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    swps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (result_valid),
        .res       (res),
        .res_stall (result_stall)
    );

    assign target_valid  = res.target_valid;
    assign target_0      = res.target[0];
    assign target_1      = res.target[1];
    assign target_2      = res.target[2];
    assign target_3      = res.target[3];
    assign target_4      = res.target[4];
    assign target_5      = res.target[5];
    assign moving        = res.moving;
    assign advanced      = res.advanced;
    assign push_rejected = res.push_rejected;

endmodule

// ===== sim/servo_waypoint_route_checker.sv =====
// Scoreboard for the servo waypoint sequencer: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module servo_waypoint_route_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  logic                             cmd,
    input  swps_pkg::angle_t                 angle_0,
    input  swps_pkg::angle_t                 angle_1,
    input  swps_pkg::angle_t                 angle_2,
    input  swps_pkg::angle_t                 angle_3,
    input  swps_pkg::angle_t                 angle_4,
    input  swps_pkg::angle_t                 angle_5,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  logic                             target_valid,
    input  swps_pkg::angle_t                 target_0,
    input  swps_pkg::angle_t                 target_1,
    input  swps_pkg::angle_t                 target_2,
    input  swps_pkg::angle_t                 target_3,
    input  swps_pkg::angle_t                 target_4,
    input  swps_pkg::angle_t                 target_5,
    input  logic                             moving,
    input  logic                             advanced,
    input  logic                             push_rejected,
    input  logic                             cfg_we,
    input  logic [swps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swps_pkg::THR_W-1:0]       cfg_data,
    output int                               failures,
    output int                               pending
);
    import swps_pkg::*;

    localparam thr_word_t ARM_LIMIT_RESET  = 16'd82;
    localparam thr_word_t HAND_LIMIT_RESET = 16'd410;

    // shadow of the waypoint FIFO and its flags
    waypoint_t route_mem [QUEUE_DEPTH];
    int        route_head;
    int        route_tail;
    int        route_len;
    logic      moving_now;
    thr_word_t arm_limit;
    thr_word_t hand_limit;
    res_t      route_results [$];

    function automatic bit joint_settled(angle_t seen, angle_t goal, thr_word_t limit);
        int err;
        err = int'(seen) - int'(goal);
        if (err < 0)
            err = -err;
        return err <= int'(limit);
    endfunction

    task automatic step_route(cmd_t op, waypoint_t angles);
        res_t r;
        bit   all_in;
        int   j;
        r = '0;
        if (op == CMD_PUSH) begin
            if (route_len >= QUEUE_DEPTH)
                r.push_rejected = 1'b1;
            else begin
                route_mem[route_tail] = angles;
                route_tail = (route_tail + 1) % QUEUE_DEPTH;
                route_len++;
            end
            moving_now = 1'b1;
        end else if (route_len == 0) begin
            moving_now = 1'b0;
        end else begin
            r.target_valid = 1'b1;
            r.target = route_mem[route_head];
            moving_now = 1'b1;
            all_in = 1'b1;
            for (j = 0; j < JOINT_COUNT; j++)
                if (!joint_settled(angles[j], r.target[j],
                                   (j == GRIPPER_JOINT) ? hand_limit : arm_limit))
                    all_in = 1'b0;
            if (all_in) begin
                r.advanced = 1'b1;
                route_head = (route_head + 1) % QUEUE_DEPTH;
                route_len--;
                moving_now = (route_len != 0);
            end
        end
        r.moving = moving_now;
        route_results.insert(route_results.size(), r);
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t      want;
        waypoint_t seen;
        int        j;
        if (!rst_n) begin
            route_head = 0;
            route_tail = 0;
            route_len = 0;
            moving_now = 1'b0;
            arm_limit = ARM_LIMIT_RESET;
            hand_limit = HAND_LIMIT_RESET;
            route_results.delete();
            failures = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ARM_THR)
                    arm_limit = cfg_data;
                else if (cfg_index == REG_HAND_THR)
                    hand_limit = cfg_data;
            end
            if (item_valid && !item_stall)
                step_route(cmd_t'(cmd),
                           {angle_5, angle_4, angle_3, angle_2, angle_1, angle_0});
            if (result_valid && !result_stall) begin
                if (route_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    failures++;
                end else begin
                    want = route_results[0];
                    route_results.delete(0);
                    seen = {target_5, target_4, target_3, target_2, target_1, target_0};
                    check_field("target_valid", want.target_valid, target_valid);
                    for (j = 0; j < JOINT_COUNT; j++)
                        check_field($sformatf("target_%0d", j),
                                    $signed(want.target[j]), $signed(seen[j]));
                    check_field("moving", want.moving, moving);
                    check_field("advanced", want.advanced, advanced);
                    check_field("push_rejected", want.push_rejected, push_rejected);
                end
            end
            pending = route_results.size();
        end
    end

endmodule

// ===== sim/tb_servo_waypoint_sequencer_core.sv =====
// Testbench top for the servo waypoint sequencer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_servo_waypoint_sequencer_core;
    import swps_pkg::*;

    localparam int ANGLE_MAX   = 2 ** (ANGLE_BITS - 1) - 1;
    localparam int ANGLE_MIN   = -(2 ** (ANGLE_BITS - 1));
    localparam int THR_MAX     = 2 ** THR_W - 1;
    localparam int MAX_GAP     = 14;
    localparam int LONG_HOLD   = 400;     // receiver hold-off long enough to back up the input
    localparam int PHASE_BEATS = 150;     // random beats per threshold setting
    localparam int DRAIN_WAIT  = 10;      // idle wait after the scoreboard drains
    localparam int CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic                 cmd;
    angle_t               angle_0, angle_1, angle_2, angle_3, angle_4, angle_5;
    logic                 result_valid;
    logic                 result_stall;
    logic                 target_valid;
    angle_t               target_0, target_1, target_2, target_3, target_4, target_5;
    logic                 moving;
    logic                 advanced;
    logic                 push_rejected;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;
    int                   failures;
    int                   pending;
    int                   cycle_count;

    // Thresholds as last written; the stimulus uses them to aim status beats
    // just inside or just outside the arrival window.
    int        arm_cap;
    int        hand_cap;
    // Waypoints the block should still be holding, front first. Only used to
    // shape status beats; all checking lives in the scoreboard.
    waypoint_t route_plan [$];
    // Sender pacing: stretches of back-to-back beats alternate with random gaps.
    int        tx_mode_left;
    bit        tx_burst;
    // Set by the stimulus, consumed by the receiver to start one long hold-off.
    bit        long_hold_req;

    servo_waypoint_sequencer_core DUT (.*);

    servo_waypoint_route_checker route_checker (.*);

    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side. Each pass draws a hold-off, keeps stall high through it,
    // then drops stall until one result beat is taken. Stall is only ever
    // touched at the falling edge.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        int rx_mode_left;
        bit rx_burst;
        result_stall = 1'b0;
        rx_mode_left = 0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever begin
            if (rx_mode_left == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
                rx_mode_left = $urandom_range(20, 60);
            end
            rx_mode_left--;
            hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            @(negedge clk);
            if (hold > 0) begin
                result_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        if (tx_mode_left == 0) begin
            tx_burst = ($urandom_range(0, 2) == 0);
            tx_mode_left = $urandom_range(20, 60);
        end
        tx_mode_left--;
        return tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic angle_t clamp_angle(int v);
        if (v > ANGLE_MAX)
            return angle_t'(ANGLE_MAX);
        if (v < ANGLE_MIN)
            return angle_t'(ANGLE_MIN);
        return angle_t'(v);
    endfunction

    function automatic waypoint_t uniform_waypoint(int v);
        waypoint_t wp;
        for (int j = 0; j < JOINT_COUNT; j++)
            wp[j] = angle_t'(v);
        return wp;
    endfunction

    // Mostly full-range angles, with the two rails mixed in.
    function automatic waypoint_t random_waypoint();
        waypoint_t wp;
        for (int j = 0; j < JOINT_COUNT; j++)
            case ($urandom_range(0, 9))
                0:       wp[j] = angle_t'(ANGLE_MIN);
                1:       wp[j] = angle_t'(ANGLE_MAX);
                default: wp[j] = angle_t'($urandom);
            endcase
        return wp;
    endfunction

    function automatic int cap_for(int j);
        return (j == GRIPPER_JOINT) ? hand_cap : arm_cap;
    endfunction

    // One input beat. Valid is raised at a falling edge and held, payload
    // steady, until a rising edge sees stall low.
    task automatic send_beat(cmd_t op, waypoint_t wp);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        cmd = op;
        angle_0 = wp[0];
        angle_1 = wp[1];
        angle_2 = wp[2];
        angle_3 = wp[3];
        angle_4 = wp[4];
        angle_5 = wp[5];
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic issue_push(waypoint_t wp);
        send_beat(CMD_PUSH, wp);
        if (route_plan.size() < QUEUE_DEPTH)
            route_plan.insert(route_plan.size(), wp);
    endtask

    // Status beat whose outcome is known by construction.
    task automatic send_status(waypoint_t meas, bit pops);
        send_beat(CMD_STATUS, meas);
        if (pops && route_plan.size() > 0)
            route_plan.delete(0);
    endtask

    // Aim a status beat at the front waypoint. A miss pushes one joint just
    // past its window (or further) while the rest are random; where no joint
    // can be pushed out of range, the beat turns into a hit. A hit keeps every
    // joint inside its window, often right on the edge.
    task automatic build_status(input waypoint_t front, input bit want_miss,
                                output waypoint_t meas, output bit lands);
        int t;
        int cap;
        int k;
        int j;
        int d;
        int room;
        int start;
        bit hi_ok;
        bit lo_ok;
        bit found;
        found = 1'b0;
        meas = random_waypoint();
        if (want_miss) begin
            start = $urandom_range(0, JOINT_COUNT - 1);
            for (j = 0; j < JOINT_COUNT && !found; j++) begin
                k = (start + j) % JOINT_COUNT;
                t = int'($signed(front[k]));
                cap = cap_for(k);
                hi_ok = (t + cap + 1 <= ANGLE_MAX);
                lo_ok = (t - cap - 1 >= ANGLE_MIN);
                if (hi_ok && (!lo_ok || $urandom_range(0, 1) == 1)) begin
                    room = ANGLE_MAX - (t + cap + 1);
                    d = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, room));
                    meas[k] = angle_t'(t + cap + 1 + d);
                    found = 1'b1;
                end else if (lo_ok) begin
                    room = (t - cap - 1) - ANGLE_MIN;
                    d = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, room));
                    meas[k] = angle_t'(t - cap - 1 - d);
                    found = 1'b1;
                end
            end
        end
        lands = !found;
        if (lands)
            for (j = 0; j < JOINT_COUNT; j++) begin
                t = int'($signed(front[j]));
                cap = cap_for(j);
                case ($urandom_range(0, 3))
                    0:       d = cap;
                    1:       d = -cap;
                    default: d = int'($urandom_range(0, cap));
                endcase
                if ($urandom_range(0, 1) == 1)
                    d = -d;
                meas[j] = clamp_angle(t + d);
            end
    endtask

    // Random traffic. The push share changes every few dozen beats so the
    // FIFO swings between nearly empty and full (rejected pushes included).
    task automatic run_random(int beats);
        int        n;
        int        push_bias;
        bit        lands;
        waypoint_t meas;
        push_bias = 45;
        for (n = 0; n < beats; n++) begin
            if (n % 30 == 0)
                case ($urandom_range(0, 2))
                    0:       push_bias = 20;
                    1:       push_bias = 45;
                    default: push_bias = 80;
                endcase
            if ($urandom_range(0, 99) < push_bias)
                issue_push(random_waypoint());
            else if (route_plan.size() == 0)
                send_beat(CMD_STATUS, random_waypoint());
            else begin
                build_status(route_plan[0], $urandom_range(0, 3) == 0, meas, lands);
                send_status(meas, lands);
            end
        end
    endtask

    // Thresholds only change with nothing in flight: every beat gives one
    // result, so an empty scoreboard plus the DRAIN_WAIT settle time means the core is idle.
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = THR_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_ARM_THR)
            arm_cap = value;
        else
            hand_cap = value;
    endtask

    task automatic set_limits(int arm, int hand);
        wait_idle();
        write_limit(REG_ARM_THR, arm);
        write_limit(REG_HAND_THR, hand);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        waypoint_t top_rail;
        waypoint_t low_rail;
        waypoint_t meas;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        cmd = CMD_PUSH;
        {angle_0, angle_1, angle_2, angle_3, angle_4, angle_5} = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ARM_THR;
        cfg_data = '0;
        arm_cap = 82;
        hand_cap = 410;
        tx_mode_left = 0;
        tx_burst = 1'b0;
        long_hold_req = 1'b0;
        top_rail = uniform_waypoint(ANGLE_MAX);
        low_rail = uniform_waypoint(ANGLE_MIN);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset thresholds.
        // status on an empty FIFO: no target, moving stays low
        send_status(low_rail, 1'b0);
        issue_push(top_rail);
        issue_push(low_rail);
        // every joint exactly on its window edge: arrives
        meas = uniform_waypoint(ANGLE_MAX - arm_cap);
        meas[GRIPPER_JOINT] = angle_t'(ANGLE_MAX - hand_cap);
        send_status(meas, 1'b1);
        // one arm joint one step outside its window
        meas = low_rail;
        meas[0] = angle_t'(ANGLE_MIN + arm_cap + 1);
        send_status(meas, 1'b0);
        // gripper one step outside its (wider) window
        meas = low_rail;
        meas[GRIPPER_JOINT] = angle_t'(ANGLE_MIN + hand_cap + 1);
        send_status(meas, 1'b0);
        // edges from below: arrives and empties the FIFO, moving drops
        meas = uniform_waypoint(ANGLE_MIN + arm_cap);
        meas[GRIPPER_JOINT] = angle_t'(ANGLE_MIN + hand_cap);
        send_status(meas, 1'b1);
        send_status(top_rail, 1'b0);
        // fill all 16 slots, then one push that gets dropped
        issue_push(low_rail);
        issue_push(top_rail);
        repeat (QUEUE_DEPTH - 2) issue_push(random_waypoint());
        issue_push(random_waypoint());

        // Widest windows: a rail-to-rail error still counts as arrived.
        set_limits(THR_MAX, THR_MAX);
        send_status(top_rail, 1'b1);
        send_status(low_rail, 1'b1);
        run_random(PHASE_BEATS);

        // Zero windows: only an exact match arrives.
        set_limits(0, 0);
        run_random(PHASE_BEATS);

        // Arbitrary windows, plus one long receiver hold-off so the result
        // side backs up and the input has to stall.
        set_limits($urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX));
        long_hold_req = 1'b1;
        run_random(PHASE_BEATS);

        // Narrow windows of realistic size.
        set_limits($urandom_range(0, 300), $urandom_range(0, 1000));
        run_random(PHASE_BEATS);

        // Mixed extremes: arm exact, gripper anything.
        set_limits(0, THR_MAX);
        run_random(PHASE_BEATS);

        // Back to the power-up values, written explicitly.
        set_limits(82, 410);
        run_random(PHASE_BEATS);

        @(negedge clk);
        item_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swps_pkg.sv
rtl/swps_front.sv
rtl/swps_back.sv
rtl/servo_waypoint_sequencer_core.sv
sim/servo_waypoint_route_checker.sv
sim/tb_servo_waypoint_sequencer_core.sv
